// ----- hw/rtl/fet_pkg.sv -----
`default_nettype none

package fet_pkg;

  // field widths of the item channels
  localparam int COORD_WIDTH     = 32;
  localparam int COUNT_WIDTH     = 16;
  localparam int FRAC_BITS_DEF   = 28;

  // multiplier operand carries two guard bits for the cardioid terms
  localparam int MUL_WIDTH       = COORD_WIDTH + 2;
  localparam int PROD_WIDTH      = 2 * MUL_WIDTH;
  localparam int MUL_LANES       = 3;

  // configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = (COORD_WIDTH > COUNT_WIDTH) ? COORD_WIDTH : COUNT_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ITER = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_RE = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_IM = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(500);

  // input mode codes
  localparam logic MODE_JULIA  = 1'b0;
  localparam logic MODE_MANDEL = 1'b1;

  typedef struct packed {
    logic                          mode;
    logic signed [COORD_WIDTH-1:0] point_re;
    logic signed [COORD_WIDTH-1:0] point_im;
  } fet_in_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] iteration_count;
    logic                   did_escape;
  } fet_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CARD_SQ,
    S_CARD_PROD,
    S_CARD_CMP,
    S_MUL,
    S_UPD,
    S_EMIT
  } fet_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fet_mul_unit.sv -----
`default_nettype none

module fet_mul_unit (
  input  wire logic                                  clk,
  input  wire logic signed [fet_pkg::MUL_WIDTH-1:0]  op_a [fet_pkg::MUL_LANES],
  input  wire logic signed [fet_pkg::MUL_WIDTH-1:0]  op_b [fet_pkg::MUL_LANES],
  output logic signed      [fet_pkg::PROD_WIDTH-1:0] prod [fet_pkg::MUL_LANES]
);
  import fet_pkg::*;

  logic signed [PROD_WIDTH-1:0] prod_r [MUL_LANES];

  // three signed multipliers, product registered
  always_ff @(posedge clk) begin
    for (int i = 0; i < MUL_LANES; i++) begin
      prod_r[i] <= PROD_WIDTH'(op_a[i]) * PROD_WIDTH'(op_b[i]);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ----- hw/rtl/fet_step.sv -----
`default_nettype none

module fet_step #(
  parameter int FRAC_BITS = fet_pkg::FRAC_BITS_DEF
) (
  input  wire logic signed [fet_pkg::PROD_WIDTH-1:0]  prod [fet_pkg::MUL_LANES],
  input  wire logic signed [fet_pkg::COORD_WIDTH-1:0] c_re,
  input  wire logic signed [fet_pkg::COORD_WIDTH-1:0] c_im,
  output logic                                        escaped,
  output logic signed      [fet_pkg::COORD_WIDTH-1:0] z_re_nxt,
  output logic signed      [fet_pkg::COORD_WIDTH-1:0] z_im_nxt,
  output logic signed      [fet_pkg::MUL_WIDTH-1:0]   card_q,
  output logic                                        card_in_box,
  output logic                                        card_inside
);
  import fet_pkg::*;

  localparam int W          = COORD_WIDTH;
  localparam int SW         = PROD_WIDTH + 2;
  localparam int ESC_SHIFT  = 2 * FRAC_BITS + 2;
  localparam int BW         = ((W > FRAC_BITS + 2) ? W : FRAC_BITS + 2) + 1;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  // cardioid bounding box, 0.65 rounded to nearest
  localparam logic [63:0] UNIT64  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] Q20     = UNIT64 / 64'd20;
  localparam logic [63:0] R20     = UNIT64 % 64'd20;
  localparam logic [63:0] Y065_64 = 64'd13 * Q20 + (64'd13 * R20 + 64'd10) / 64'd20;
  localparam logic signed [BW-1:0] QTR_B  = BW'(1) << (FRAC_BITS - 2);
  localparam logic signed [BW-1:0] BOX_XLO = -(QTR_B + QTR_B + QTR_B);
  localparam logic signed [BW-1:0] BOX_XHI = BW'(3) << (FRAC_BITS - 3);
  localparam logic signed [BW-1:0] BOX_Y   = BW'(Y065_64);

  logic signed [PROD_WIDTH:0]   sq_sum;
  logic signed [PROD_WIDTH:0]   re_diff;
  logic signed [PROD_WIDTH:0]   re_sh;
  logic signed [PROD_WIDTH:0]   im_dbl;
  logic signed [PROD_WIDTH:0]   im_sh;
  logic signed [SW-1:0]         re_sum;
  logic signed [SW-1:0]         im_sum;
  logic signed [SW-1:0]         card_lhs;
  logic signed [SW-1:0]         card_rhs;
  logic signed [BW-1:0]         box_x;
  logic signed [BW-1:0]         box_y;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[W-1:0];
  endfunction

  // magnitude squared against 4, exact at double fraction precision
  assign sq_sum  = (PROD_WIDTH+1)'(prod[0]) + (PROD_WIDTH+1)'(prod[1]);
  assign escaped = (sq_sum >>> ESC_SHIFT) != '0;

  // z*z + c, floor shift then saturate
  assign re_diff  = (PROD_WIDTH+1)'(prod[0]) - (PROD_WIDTH+1)'(prod[1]);
  assign re_sh    = re_diff >>> FRAC_BITS;
  assign im_dbl   = $signed({prod[2], 1'b0});
  assign im_sh    = im_dbl >>> FRAC_BITS;
  assign re_sum   = SW'(re_sh) + SW'(c_re);
  assign im_sum   = SW'(im_sh) + SW'(c_im);
  assign z_re_nxt = sat_w(re_sum);
  assign z_im_nxt = sat_w(im_sum);

  // q = floor(a^2 + y^2), non-negative
  assign card_q = sq_sum[FRAC_BITS +: MUL_WIDTH];

  // 4*q*(q+a) < y^2
  assign card_lhs    = $signed({prod[0], 2'b00});
  assign card_rhs    = SW'(prod[1]);
  assign card_inside = card_lhs < card_rhs;

  // box test on c
  assign box_x       = BW'(c_re);
  assign box_y       = BW'(c_im);
  assign card_in_box = (BOX_XLO < box_x) && (box_x < BOX_XHI) &&
                       (box_y < BOX_Y) && (-BOX_Y < box_y);

endmodule

`default_nettype wire

// ----- hw/rtl/fractal_escape_time_iterator.sv -----
`default_nettype none

// Escape-time iterator for Mandelbrot and Julia points in signed fixed point
// (COORD_WIDTH bits, FRAC_BITS fraction bits). One item is worked at a time;
// in_stall is high from acceptance until the result has moved into the output
// register. A shared unit of three registered multipliers does one complex
// square per pass, and each iteration is a multiply state (S_MUL) followed
// by an add/saturate/escape-test state (S_UPD). A Mandelbrot point first
// checks the cardioid box; a point in the box also runs the cardioid test
// (S_CARD_PROD, S_CARD_CMP), and a point inside the main cardioid answers
// max_iterations without iterating; any other point goes on to iterate.
// The output register lets a finished result wait while the next item is
// taken. Configuration writes are accepted at any time (cfg_ready stays high)
// but should only be issued while no item is in flight.
module fractal_escape_time_iterator #(
  parameter int FRAC_BITS = fet_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_valid,
  output logic                                           in_stall,
  input  wire fet_pkg::fet_in_t                          in_item,
  output logic                                           out_valid,
  input  wire logic                                      out_stall,
  output fet_pkg::fet_out_t                              out_item,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [fet_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
  input  wire logic [fet_pkg::CFG_DATA_WIDTH-1:0]        cfg_data
);
  import fet_pkg::*;

  localparam int W = COORD_WIDTH;

  localparam logic signed [MUL_WIDTH-1:0] QUARTER = MUL_WIDTH'(1) << (FRAC_BITS - 2);

  fet_state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0]   max_iter_r;
  logic signed [W-1:0]      julia_re_r;
  logic signed [W-1:0]      julia_im_r;

  logic signed [W-1:0]      z_re_r;
  logic signed [W-1:0]      z_im_r;
  logic signed [W-1:0]      c_re_r;
  logic signed [W-1:0]      c_im_r;
  logic [COUNT_WIDTH-1:0]   n_r;
  fet_out_t                 res_r;
  fet_out_t                 out_item_r;
  logic                     out_valid_r;

  logic signed [MUL_WIDTH-1:0]  op_a [MUL_LANES];
  logic signed [MUL_WIDTH-1:0]  op_b [MUL_LANES];
  logic signed [PROD_WIDTH-1:0] prod [MUL_LANES];

  logic                         escaped;
  logic signed [W-1:0]          z_re_nxt;
  logic signed [W-1:0]          z_im_nxt;
  logic signed [MUL_WIDTH-1:0]  card_q;
  logic                         card_in_box;
  logic                         card_inside;

  logic signed [MUL_WIDTH-1:0]  card_a;
  logic signed [MUL_WIDTH-1:0]  card_y;
  logic signed [MUL_WIDTH-1:0]  zr_m;
  logic signed [MUL_WIDTH-1:0]  zi_m;

  logic in_accept;
  logic out_free;
  logic iter_done;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign iter_done = (n_r >= max_iter_r) || escaped;

  // shared multiplier and step logic
  fet_mul_unit u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  fet_step #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .prod        (prod),
    .c_re        (c_re_r),
    .c_im        (c_im_r),
    .escaped     (escaped),
    .z_re_nxt    (z_re_nxt),
    .z_im_nxt    (z_im_nxt),
    .card_q      (card_q),
    .card_in_box (card_in_box),
    .card_inside (card_inside)
  );

  // operand selection
  assign card_a = MUL_WIDTH'(c_re_r) - QUARTER;
  assign card_y = MUL_WIDTH'(c_im_r);
  assign zr_m   = MUL_WIDTH'(z_re_r);
  assign zi_m   = MUL_WIDTH'(z_im_r);

  always_comb begin
    op_a[0] = zr_m;
    op_b[0] = zr_m;
    op_a[1] = zi_m;
    op_b[1] = zi_m;
    op_a[2] = zr_m;
    op_b[2] = zi_m;
    if (state_r == S_CARD_SQ) begin
      op_a[0] = card_a;
      op_b[0] = card_a;
      op_a[1] = card_y;
      op_b[1] = card_y;
    end else if (state_r == S_CARD_PROD) begin
      op_a[0] = card_q;
      op_b[0] = card_q + card_a;
      op_a[1] = card_y;
      op_b[1] = card_y;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_item.mode == MODE_MANDEL) ? S_CARD_SQ : S_MUL;
        end
      end
      S_CARD_SQ: begin
        state_nxt = card_in_box ? S_CARD_PROD : S_MUL;
      end
      S_CARD_PROD: begin
        state_nxt = S_CARD_CMP;
      end
      S_CARD_CMP: begin
        state_nxt = card_inside ? S_EMIT : S_MUL;
      end
      S_MUL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = iter_done ? S_EMIT : S_MUL;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RESET;
      julia_re_r <= '0;
      julia_im_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_ITER: max_iter_r <= cfg_data[COUNT_WIDTH-1:0];
        CFG_JULIA_RE: julia_re_r <= cfg_data[W-1:0];
        CFG_JULIA_IM: julia_im_r <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      n_r <= '0;
      if (in_item.mode == MODE_MANDEL) begin
        z_re_r <= '0;
        z_im_r <= '0;
        c_re_r <= in_item.point_re;
        c_im_r <= in_item.point_im;
      end else begin
        z_re_r <= in_item.point_re;
        z_im_r <= in_item.point_im;
        c_re_r <= julia_re_r;
        c_im_r <= julia_im_r;
      end
    end else if (state_r == S_UPD && !iter_done) begin
      z_re_r <= z_re_nxt;
      z_im_r <= z_im_nxt;
      n_r    <= n_r + 1'b1;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (state_r == S_CARD_CMP && card_inside) begin
      res_r.iteration_count <= max_iter_r;
      res_r.did_escape      <= 1'b0;
    end else if (state_r == S_UPD && iter_done) begin
      res_r.iteration_count <= n_r;
      res_r.did_escape      <= escaped;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_item_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
